### sv/utt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_pkg: shared types and helpers for the UTF-16LE to UTF-8 transcoder
// Beat formats, the code point record passed from front to back, and the
// UTF-8 byte formatter.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [15:0] Cu2ByteMin  = 16'h0080;
  localparam logic [15:0] Cu3ByteMin  = 16'h0800;
  localparam logic [15:0] SurHighMin  = 16'hD800;
  localparam logic [15:0] SurHighMax  = 16'hDBFF;
  localparam logic [15:0] SurLowMin   = 16'hDC00;
  localparam logic [15:0] SurLowMax   = 16'hDFFF;
  localparam logic [CpW-1:0] SuppBase = 21'h010000;

  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
  } out_beat_t;

  // One code point to encode, with its byte count minus one.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic [1:0]     len_m1;
  } cp_rec_t;

  // Byte number idx (0 = lead byte) of the UTF-8 form of cp.
  function automatic logic [7:0] utf8_byte_at(input logic [CpW-1:0] cp,
                                              input logic [1:0] len_m1,
                                              input logic [1:0] idx);
    logic [1:0] grp;
    logic [5:0] six;
    logic [7:0] res;
    grp = len_m1 - idx;
    case (grp)
      2'd0:    six = cp[5:0];
      2'd1:    six = cp[11:6];
      2'd2:    six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (idx != 2'd0) begin
      res = {2'b10, six};
    end else begin
      case (len_m1)
        Len1:    res = {1'b0, cp[6:0]};
        Len2:    res = {3'b110, cp[10:6]};
        Len3:    res = {4'b1110, cp[15:12]};
        default: res = {5'b11110, cp[20:18]};
      endcase
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### sv/utt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_front: input stage
// Accepts code units, tracks the held high surrogate and end of string,
// and pushes one code point record per unit that yields output.
// ----------------------------------------------------------------------------
module utt_front
  import utt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cp_rec_t       q_rec
);

  logic [9:0] held_bits_r, held_bits_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       ended_r, ended_nxt;
  logic       accept;
  logic [15:0] cu;
  logic       is_sur, is_high, is_low;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cu       = in_data.code_unit;
  assign is_sur   = (cu >= SurHighMin) && (cu <= SurLowMax);
  assign is_high  = (cu >= SurHighMin) && (cu <= SurHighMax);
  assign is_low   = (cu >= SurLowMin) && (cu <= SurLowMax);

  always_comb begin
    held_bits_nxt  = held_bits_r;
    held_valid_nxt = held_valid_r;
    ended_nxt      = ended_r;
    q_push         = 1'b0;
    q_rec.cp       = {5'd0, cu};
    q_rec.len_m1   = Len3;
    if (cu < Cu2ByteMin) begin
      q_rec.len_m1 = Len1;
    end else if (cu < Cu3ByteMin) begin
      q_rec.len_m1 = Len2;
    end
    if (accept) begin
      if (!ended_r) begin
        if (cu == 16'd0) begin
          held_valid_nxt = 1'b0;
          ended_nxt      = 1'b1;
        end else if (held_valid_r && is_low) begin
          held_valid_nxt = 1'b0;
          q_push         = 1'b1;
          q_rec.cp       = SuppBase + {1'b0, held_bits_r, cu[9:0]};
          q_rec.len_m1   = Len4;
        end else begin
          held_valid_nxt = 1'b0;
          if (!is_sur) begin
            q_push = 1'b1;
          end else if (is_high && !in_data.string_last) begin
            held_bits_nxt  = cu[9:0];
            held_valid_nxt = 1'b1;
          end
        end
      end
      if (in_data.string_last) begin
        held_valid_nxt = 1'b0;
        held_bits_nxt  = 10'd0;
        ended_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bits_r  <= 10'd0;
      held_valid_r <= 1'b0;
      ended_r      <= 1'b0;
    end else begin
      held_bits_r  <= held_bits_nxt;
      held_valid_r <= held_valid_nxt;
      ended_r      <= ended_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/utt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_queue: two-entry record queue
// Decouples the front from the byte serializer.
// ----------------------------------------------------------------------------
module utt_queue
  import utt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire cp_rec_t push_rec,
  output logic         full,
  input  wire logic    pop,
  output logic         not_empty,
  output cp_rec_t      head
);

  cp_rec_t    slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

endmodule
`default_nettype wire

### sv/utt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_back: byte serializer
// Takes code point records and sends their UTF-8 bytes one beat at a time
// through an output register.
// ----------------------------------------------------------------------------
module utt_back
  import utt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_not_empty,
  input  wire cp_rec_t q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_beat_t    out_data
);

  cp_rec_t    work_r;
  logic       work_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  logic       can_emit, emit, last_byte;

  assign can_emit  = !out_valid_r || !out_stall;
  assign emit      = can_emit && work_valid_r;
  assign last_byte = (idx_r == work_r.len_m1);
  // Refill the work register when empty or when its last byte goes out.
  assign q_pop     = !work_valid_r || (emit && last_byte);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_not_empty) begin
      work_r <= q_head;
    end
    if (emit) begin
      out_data_r.utf8_byte <= utf8_byte_at(work_r.cp, work_r.len_m1, idx_r);
      out_data_r.run_last  <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        work_valid_r <= q_not_empty;
        idx_r        <= 2'd0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/utf16le_to_utf8_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder: UTF-16 code units in, UTF-8 bytes out
// Accepts one code unit per beat and returns its UTF-8 bytes, one per beat,
// with run_last on the final byte of each unit. Surrogate pairs become one
// four-byte sequence; unpaired surrogates are dropped silently. A zero unit
// ends the string and later units are ignored until string_last.
// ----------------------------------------------------------------------------
//
// A unit is accepted every cycle while the record queue has room; the output
// side sends one byte per cycle while out_stall is low, so a unit yields 1
// to 4 bytes (1 for ASCII, 2 below U+0800, 3 for other BMP code points, 4
// for a surrogate pair, 0 for dropped units). Sustained throughput is set
// by the byte serializer. An accepted unit passes a queue slot, the work
// register and the output register before its first byte goes out. in_stall
// rises when the queue is full; out_valid has no combinational path from out_stall.
//
// Structure:
//   utt_front  - surrogate and end-of-string tracking, classification
//   utt_queue  - two-entry code point record queue
//   utt_back   - byte serializer with a registered output beat
// ----------------------------------------------------------------------------
module utf16le_to_utf8_transcoder
  import utt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_data
);

  logic    q_full, q_push, q_pop, q_not_empty;
  cp_rec_t q_rec, q_head;

  utt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_rec)
  );

  utt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  utt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
